@@ src/lncs_pkg.sv @@
`default_nettype none
package lncs_pkg;

   localparam int DEF_ROWS = 8;
   localparam int DEF_COLS = 4;
   localparam int DEF_DIM  = 768;

   localparam int CNUM_W = 5;
   localparam int EIDX_W = 10;
   localparam int VAL_W  = 16;
   localparam int GRP_W  = 3;
   localparam int SUM_W  = 26;

   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_FEATURE = 1'b1;

   // one item travelling down the chain, with the running best of the search
   typedef struct packed {
      logic                    valid;
      logic                    cmd;
      logic [CNUM_W-1:0]       cnum;
      logic [EIDX_W-1:0]       eidx;
      logic signed [VAL_W-1:0] value;
      logic                    last;
      logic                    in_range;
      logic [SUM_W-1:0]        best_sum;
      logic [GRP_W-1:0]        best_group;
   } tok_type;

endpackage
`default_nettype wire

@@ src/lncs_cell.sv @@
`default_nettype none
module lncs_cell #(
   parameter int ID   = 0,
   parameter int COLS = lncs_pkg::DEF_COLS,
   parameter int DIM  = lncs_pkg::DEF_DIM
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lncs_pkg::tok_type tok_i,
   output lncs_pkg::tok_type     tok_o
);

   localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [lncs_pkg::GRP_W-1:0] MY_GROUP = lncs_pkg::GRP_W'(ID / COLS);
   localparam bit FIRST = (ID == 0);

   logic signed [lncs_pkg::VAL_W-1:0] mem [0:DIM-1];
   logic signed [lncs_pkg::VAL_W-1:0] rd_ff;

   lncs_pkg::tok_type a_ff, b_ff, c_ff, o_ff;
   logic [lncs_pkg::VAL_W-1:0]        dist_ff, dist_in;
   logic [lncs_pkg::SUM_W-1:0]        sum_ff, sum_in, sum_base;
   logic [lncs_pkg::SUM_W:0]          sum_wide;
   logic signed [lncs_pkg::VAL_W:0]   diff;
   logic [lncs_pkg::VAL_W:0]          mag;
   logic [AW-1:0]                     addr;
   logic                              wr_en;
   lncs_pkg::tok_type                 o_in;

   assign addr  = AW'(tok_i.eidx);
   assign wr_en = tok_i.valid && (tok_i.cmd == lncs_pkg::CMD_WRITE) && tok_i.in_range
                  && (32'(tok_i.cnum) == ID);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= tok_i.value;
      end
      rd_ff <= mem[addr];
   end

   // |feature - center|
   always_comb begin
      diff    = {a_ff.value[lncs_pkg::VAL_W-1], a_ff.value} - {rd_ff[lncs_pkg::VAL_W-1], rd_ff};
      mag     = diff[lncs_pkg::VAL_W] ? (unsigned'(-diff)) : unsigned'(diff);
      dist_in = mag[lncs_pkg::VAL_W-1:0];
   end

   // the item behind a last item starts a new vector from zero
   always_comb begin
      sum_base = (c_ff.valid && (c_ff.cmd == lncs_pkg::CMD_FEATURE) && c_ff.last) ? '0 : sum_ff;
      sum_wide = {1'b0, sum_base} + (lncs_pkg::SUM_W + 1)'(dist_ff);
      if (b_ff.valid && (b_ff.cmd == lncs_pkg::CMD_FEATURE) && b_ff.in_range) begin
         sum_in = sum_wide[lncs_pkg::SUM_W] ? '1 : sum_wide[lncs_pkg::SUM_W-1:0];
      end else begin
         sum_in = sum_base;
      end
   end

   always_comb begin
      o_in = c_ff;
      if (c_ff.valid && (c_ff.cmd == lncs_pkg::CMD_FEATURE) && c_ff.last
          && (FIRST || (sum_ff < c_ff.best_sum))) begin
         o_in.best_sum   = sum_ff;
         o_in.best_group = MY_GROUP;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      if (reset) begin
         a_ff   <= '0;
         b_ff   <= '0;
         c_ff   <= '0;
         o_ff   <= '0;
         sum_ff <= '0;
      end else begin
         a_ff   <= tok_i;
         b_ff   <= a_ff;
         c_ff   <= b_ff;
         o_ff   <= o_in;
         sum_ff <= sum_in;
      end
   end

   assign tok_o = o_ff;

endmodule
`default_nettype wire

@@ src/l1_nearest_center_search.sv @@
`default_nettype none
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | command, center_number, element_index,
//         |           |                       | element_value, last_element
// rsp     | out       | rsp_valid / rsp_ready | group_index, best_distance
//
// Items enter a chain of ROWS*COLS cells, one cell per center, each with its
// own slice of the center table and its own running sum. In each cell an item
// passes registers for table read, difference, sum and compare, in that order.
// One item is taken per cycle; after the last feature item of a vector no new
// item is taken until its result has been taken. Reset clears all sums; the
// table is not cleared.
module l1_nearest_center_search #(
   parameter int ROWS = lncs_pkg::DEF_ROWS,
   parameter int COLS = lncs_pkg::DEF_COLS,
   parameter int DIM  = lncs_pkg::DEF_DIM
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [lncs_pkg::CNUM_W-1:0]       req_center_number,
   input  wire logic [lncs_pkg::EIDX_W-1:0]       req_element_index,
   input  wire logic signed [lncs_pkg::VAL_W-1:0] req_element_value,
   input  wire logic                              req_last_element,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [lncs_pkg::GRP_W-1:0]             rsp_group_index,
   output logic [lncs_pkg::SUM_W-1:0]             rsp_best_distance
);

   localparam int CENTERS = ROWS * COLS;

   lncs_pkg::tok_type chain [0:CENTERS];

   logic                       pending_ff, pending_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lncs_pkg::GRP_W-1:0] group_ff;
   logic [lncs_pkg::SUM_W-1:0] dist_ff;
   logic                       req_take, rsp_take, done;

   assign req_ready = !pending_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;

   always_comb begin
      chain[0].valid      = req_take;
      chain[0].cmd        = req_command;
      chain[0].cnum       = req_center_number;
      chain[0].eidx       = req_element_index;
      chain[0].value      = req_element_value;
      chain[0].last       = req_last_element;
      chain[0].in_range   = (32'(req_element_index) < DIM);
      chain[0].best_sum   = '0;
      chain[0].best_group = '0;
   end

   for (genvar i = 0; i < CENTERS; i++) begin : g_cell
      lncs_cell #(
         .ID   (i),
         .COLS (COLS),
         .DIM  (DIM)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (chain[i]),
         .tok_o (chain[i+1])
      );
   end

   assign done = chain[CENTERS].valid && (chain[CENTERS].cmd == lncs_pkg::CMD_FEATURE)
                 && chain[CENTERS].last;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && (req_command == lncs_pkg::CMD_FEATURE) && req_last_element) begin
         pending_in = 1'b1;
      end else if (rsp_take) begin
         pending_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         group_ff <= chain[CENTERS].best_group;
         dist_ff  <= chain[CENTERS].best_sum;
      end
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_group_index   = group_ff;
   assign rsp_best_distance = dist_ff;

   a_rsp_needs_pending : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> pending_ff)
      else $error("result held with no last item outstanding");

   a_done_single : assert property (@(posedge clock) disable iff (reset)
      done |-> (pending_ff && !rsp_valid_ff))
      else $error("search finished with no free result slot");

   a_pending_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_take |=> (!pending_ff && !rsp_valid_ff))
      else $error("outstanding flag not cleared after result taken");

   a_no_take_while_pending : assert property (@(posedge clock) disable iff (reset)
      (pending_ff && !rsp_take) |=> !chain[0].valid)
      else $error("item entered chain while a result is outstanding");

endmodule
`default_nettype wire

@@ tb/tb_l1_nearest_center_search.sv @@
`default_nettype none
module tb_l1_nearest_center_search;
   import lncs_pkg::*;

   localparam int CENTERS = DEF_ROWS * DEF_COLS;
   localparam int DIM = DEF_DIM;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam int RAND_ITEMS = 120;
   localparam int TAIL_CYCLES = 300;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic [GRP_W-1:0] grp;
      logic [SUM_W-1:0] l1;
   } nearest_type;

   typedef struct {
      logic cmd;
      int   cnum;
      int   eidx;
      int   val;
      logic last;
      bit   chk;
      int   grp;
      int   l1;
   } dir_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_command;
   logic [CNUM_W-1:0] req_center_number;
   logic [EIDX_W-1:0] req_element_index;
   logic signed [VAL_W-1:0] req_element_value;
   logic req_last_element;
   logic rsp_valid;
   logic rsp_ready;
   logic [GRP_W-1:0] rsp_group_index;
   logic [SUM_W-1:0] rsp_best_distance;

   l1_nearest_center_search dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_center_number (req_center_number),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_last_element  (req_last_element),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_group_index   (rsp_group_index),
      .rsp_best_distance (rsp_best_distance)
   );

   // shadow of the center table and running sums
   logic signed [VAL_W-1:0] centers [CENTERS][DIM];
   logic [SUM_W-1:0] l1_sums [CENTERS];
   bit loaded [CENTERS][DIM];
   int fill_cnt [DIM];
   int full_idx [$];

   nearest_type nearest_q [$];
   dir_row_type dir_tab [24];

   int err_count = 0;
   int cycles = 0;
   int sent = 0;
   int burst_left = 0;
   bit tag_chk = 0;
   int tag_grp = 0;
   int tag_l1 = 0;

   nearest_type want;
   nearest_type add_item;
   bit hit;
   logic [GRP_W-1:0] hit_grp;
   logic [SUM_W-1:0] hit_l1;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic void search_step(input logic cmd, input logic [CNUM_W-1:0] cnum,
                                       input logic [EIDX_W-1:0] eidx,
                                       input logic signed [VAL_W-1:0] val, input logic last,
                                       output bit found, output logic [GRP_W-1:0] grp,
                                       output logic [SUM_W-1:0] l1);
      int diff;
      longint s;
      int best;
      logic [SUM_W-1:0] best_sum;
      found = 0;
      grp = '0;
      l1 = '0;
      if (cmd == CMD_WRITE) begin
         if (int'(cnum) < CENTERS && int'(eidx) < DIM) begin
            centers[cnum][eidx] = val;
            if (!loaded[cnum][eidx]) begin
               loaded[cnum][eidx] = 1;
               fill_cnt[eidx]++;
               if (fill_cnt[eidx] == CENTERS) full_idx = {full_idx, int'(eidx)};
            end
         end
         return;
      end
      if (int'(eidx) < DIM) begin
         for (int c = 0; c < CENTERS; c++) begin
            diff = int'(val) - int'(centers[c][eidx]);
            if (diff < 0) diff = -diff;
            s = longint'(l1_sums[c]) + diff;
            l1_sums[c] = (s > longint'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
         end
      end
      if (!last) return;
      best = 0;
      best_sum = l1_sums[0];
      for (int c = 1; c < CENTERS; c++) begin
         if (l1_sums[c] < best_sum) begin
            best_sum = l1_sums[c];
            best = c;
         end
      end
      found = 1;
      grp = GRP_W'(best / DEF_COLS);
      l1 = best_sum;
      for (int c = 0; c < CENTERS; c++) l1_sums[c] = '0;
   endfunction

   task automatic note_mismatch(input string what, input int exp_g, input int exp_d,
                                input int got_g, input int got_d);
      err_count++;
      if (err_count <= 10)
         $display("mismatch (%s): expected group %0d distance %0d, got group %0d distance %0d",
                  what, exp_g, exp_d, got_g, got_d);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (nearest_q.size() == 0) begin
               note_mismatch("no item pending", 0, 0, rsp_group_index, rsp_best_distance);
            end else begin
               want = nearest_q.pop_front();
               if (rsp_group_index !== want.grp || rsp_best_distance !== want.l1)
                  note_mismatch("result", want.grp, want.l1, rsp_group_index,
                                rsp_best_distance);
            end
         end
         if (req_valid && req_ready) begin
            search_step(req_command, req_center_number, req_element_index,
                        req_element_value, req_last_element, hit, hit_grp, hit_l1);
            if (hit) begin
               if (tag_chk) add_item = '{GRP_W'(tag_grp), SUM_W'(tag_l1)};
               else add_item = '{hit_grp, hit_l1};
               nearest_q = {nearest_q, add_item};
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: stretches of always ready, coin flip, and mostly stalled
   initial begin
      int mode;
      rsp_ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 120)) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic logic signed [VAL_W-1:0] rand_val();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return -16'sd1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic push_req(input logic cmd, input int cnum, input int eidx,
                           input logic signed [VAL_W-1:0] val, input logic last,
                           input bit chk = 0, input int grp = 0, input int l1 = 0);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_center_number <= CNUM_W'(cnum);
      req_element_index <= EIDX_W'(eidx);
      req_element_value <= val;
      req_last_element <= last;
      tag_chk = chk;
      tag_grp = grp;
      tag_l1 = l1;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (nearest_q.size() != 0) @(posedge clock);
   endtask

   // kind: 0 zeros, 1 center*1000, 2 max positive, otherwise random
   task automatic load_column(input int e, input int kind);
      logic signed [VAL_W-1:0] v;
      for (int c = 0; c < CENTERS; c++) begin
         case (kind)
            0: v = '0;
            1: v = VAL_W'(c * 1000);
            2: v = 16'sh7FFF;
            default: v = rand_val();
         endcase
         push_req(CMD_WRITE, c, e, v, 1'($urandom_range(0, 1)));
      end
   endtask

   function automatic int fresh_index();
      int e;
      do e = $urandom_range(0, DIM - 1); while (fill_cnt[e] == CENTERS);
      return e;
   endfunction

   function automatic int feature_index();
      if ($urandom_range(0, 9) == 0) return $urandom_range(DIM, 1023);
      return full_idx[$urandom_range(0, full_idx.size() - 1)];
   endfunction

   initial begin
      int start;
      int qlen;
      int e;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_WRITE;
      req_center_number = '0;
      req_element_index = '0;
      req_element_value = '0;
      req_last_element = 1'b0;
      for (int c = 0; c < CENTERS; c++) l1_sums[c] = '0;
      for (int i = 0; i < DIM; i++) fill_cnt[i] = 0;

      dir_tab = '{
         '{CMD_FEATURE,  0, 1023,      0, 1'b1, 1'b1, 0,     0},
         '{CMD_FEATURE,  0,    0, -32768, 1'b1, 1'b1, 0, 32768},
         '{CMD_FEATURE,  0,    0,  32767, 1'b1, 1'b1, 0, 32767},
         '{CMD_FEATURE,  0,  767, -32768, 1'b1, 1'b1, 0, 65535},
         '{CMD_FEATURE,  0,  767,  32767, 1'b1, 1'b1, 0,     0},
         '{CMD_FEATURE,  0,    1,  31000, 1'b1, 1'b1, 7,     0},
         '{CMD_FEATURE,  0,    1,      0, 1'b1, 1'b1, 0,     0},
         '{CMD_FEATURE,  0,    1,  14000, 1'b1, 1'b1, 3,     0},
         '{CMD_FEATURE,  0,    1,  14500, 1'b1, 1'b1, 3,   500},  // tie: 14 beats 15
         '{CMD_WRITE,   21,    0,    100, 1'b1, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,    0,    100, 1'b1, 1'b1, 5,     0},
         '{CMD_WRITE,    3, 1023,      5, 1'b0, 1'b0, 0,     0},
         '{CMD_WRITE,   31,  768,     -1, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0, 1023, -32768, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,    0,    100, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,  767,  32767, 1'b1, 1'b1, 5,     0},
         '{CMD_FEATURE,  0,    2,   1234, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,    1,  -5000, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,  768,      7, 1'b1, 1'b0, 0,     0},
         '{CMD_WRITE,    0,  767, -32768, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,  767, -32768, 1'b1, 1'b1, 0,     0},
         '{CMD_WRITE,   21,    0,      0, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,    0,  32767, 1'b0, 1'b0, 0,     0},
         '{CMD_FEATURE,  0,  767,  32767, 1'b1, 1'b1, 0, 32767}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_column(0, 0);
      load_column(1, 1);
      load_column(767, 2);
      load_column(2, 3);
      repeat (4) load_column(fresh_index(), 3);

      foreach (dir_tab[i])
         push_req(dir_tab[i].cmd, dir_tab[i].cnum, dir_tab[i].eidx,
                  VAL_W'(dir_tab[i].val), dir_tab[i].last, dir_tab[i].chk,
                  dir_tab[i].grp, dir_tab[i].l1);

      drain();

      start = sent;
      while (sent - start < RAND_ITEMS) begin
         if ($urandom_range(0, 19) == 0 && full_idx.size() < DIM)
            load_column(fresh_index(), 3);
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 9))
               0, 1: e = $urandom_range(0, DIM - 1);
               2: e = $urandom_range(DIM, 1023);
               default: e = full_idx[$urandom_range(0, full_idx.size() - 1)];
            endcase
            push_req(CMD_WRITE, $urandom_range(0, CENTERS - 1), e, rand_val(),
                     1'($urandom_range(0, 1)));
         end
         qlen = $urandom_range(1, 10);
         for (int k = 0; k < qlen; k++)
            push_req(CMD_FEATURE, $urandom_range(0, CENTERS - 1), feature_index(), rand_val(),
                     (k == qlen - 1) && ($urandom_range(0, 14) != 0));
         if ($urandom_range(0, 24) == 0) drain();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (nearest_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
